>>> rtl/core/ean13_barcode_encoder_macros.svh
// Assertion macros used by the EAN-13 encoder checker.
`ifndef EAN13_BARCODE_ENCODER_MACROS_SVH
`define EAN13_BARCODE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EAN13_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EAN13_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ean13_pkg.sv
// Types, constants and code tables of the EAN-13 encoder.
`default_nettype none

package ean13_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} req_t;

	typedef struct packed {
		logic [6:0] modules;
		logic [2:0] module_count;
		logic       code_done;
		logic [1:0] status;
		logic       run_last;
	} rsp_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_LENGTH    = 2'd1;
	localparam logic [1:0] STATUS_NON_DIGIT = 2'd2;
	localparam logic [1:0] STATUS_CHECK     = 2'd3;

	localparam logic [3:0] LAST_POSITION = 4'd12;
	localparam logic [3:0] CENTRE_POSITION = 4'd6;

	localparam logic [6:0] GUARD_SIDE   = 7'h05;
	localparam logic [6:0] GUARD_CENTRE = 7'h0A;

	localparam logic [2:0] COUNT_NONE   = 3'd0;
	localparam logic [2:0] COUNT_SIDE   = 3'd3;
	localparam logic [2:0] COUNT_CENTRE = 3'd5;
	localparam logic [2:0] COUNT_DIGIT  = 3'd7;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	function automatic logic [6:0] r_code_of(input logic [3:0] digit);
		logic [6:0] code;
		unique case (digit)
			4'd0: code = 7'h72;
			4'd1: code = 7'h66;
			4'd2: code = 7'h6C;
			4'd3: code = 7'h42;
			4'd4: code = 7'h5C;
			4'd5: code = 7'h4E;
			4'd6: code = 7'h50;
			4'd7: code = 7'h44;
			4'd8: code = 7'h48;
			4'd9: code = 7'h74;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

	function automatic logic [5:0] parity_of(input logic [3:0] digit);
		logic [5:0] pattern;
		unique case (digit)
			4'd0: pattern = 6'h00;
			4'd1: pattern = 6'h0B;
			4'd2: pattern = 6'h0D;
			4'd3: pattern = 6'h0E;
			4'd4: pattern = 6'h13;
			4'd5: pattern = 6'h19;
			4'd6: pattern = 6'h1C;
			4'd7: pattern = 6'h15;
			4'd8: pattern = 6'h16;
			4'd9: pattern = 6'h1A;
			default: pattern = 6'h00;
		endcase
		return pattern;
	endfunction

	function automatic logic [6:0] reverse7(input logic [6:0] value);
		logic [6:0] flipped;
		for (int i = 0; i < 7; i++) begin
			flipped[6 - i] = value[i];
		end
		return flipped;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/ean13_barcode_encoder.sv
// EAN-13 encoder: turns a stream of code characters into bar module groups.
// One character is taken per clock while the four-entry result queue has room for two more
// results; the queue is what sets the rate. Each character yields one result, except the
// seventh and thirteenth digits, which yield two (digit plus centre or end guard); an ignored
// character after an error yields none. A character's results are written into the queue at
// the edge that accepts it, and the first of them is offered on the output in the next cycle
// when the queue was empty before.
`default_nettype none

module ean13_barcode_encoder (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  wire ean13_pkg::req_t req,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output ean13_pkg::rsp_t   rsp
);
	import ean13_pkg::*;

	logic [3:0] position_q;
	logic [5:0] parity_q;
	logic [3:0] sum_q;
	logic       skip_q;

	logic [3:0] position_d;
	logic [5:0] parity_d;
	logic [3:0] sum_d;
	logic       skip_d;

	rsp_t       res0;
	rsp_t       res1;
	logic [1:0] res_n;

	rsp_t       queue_q [4];
	logic [1:0] rd_ptr_q;
	logic [1:0] wr_ptr_q;
	logic [2:0] count_q;

	logic       req_take;
	logic       rsp_take;

	logic       is_digit;
	logic [3:0] digit;
	logic [6:0] r_code;
	logic [4:0] product;
	logic [5:0] sum_raw;
	logic [3:0] sum_mod;
	logic [3:0] check;
	logic [2:0] parity_idx;
	logic [6:0] left_code;
	logic       length_err;

	assign req_stall = count_q > 3'd2;
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = count_q != 3'd0;
	assign rsp_take  = rsp_valid && !rsp_stall;
	assign rsp       = queue_q[rd_ptr_q];

	assign is_digit   = (req.char_code >= ASCII_ZERO) && (req.char_code <= ASCII_NINE);
	assign digit      = 4'(req.char_code - ASCII_ZERO);
	assign r_code     = r_code_of(digit);
	assign product    = position_q[0] ? 5'(5'(digit) * 5'd3) : 5'(digit);
	assign sum_raw    = 6'(sum_q) + 6'(product);
	assign check      = (sum_q == 4'd0) ? 4'd0 : 4'(4'd10 - sum_q);
	assign parity_idx = 3'(CENTRE_POSITION - position_q);
	assign left_code  = parity_q[parity_idx] ? reverse7(r_code) : ~r_code;
	assign length_err = (position_q >= LAST_POSITION) ? !req.last_char : req.last_char;

	always_comb begin
		priority if (sum_raw >= 6'd30) begin
			sum_mod = 4'(sum_raw - 6'd30);
		end else if (sum_raw >= 6'd20) begin
			sum_mod = 4'(sum_raw - 6'd20);
		end else if (sum_raw >= 6'd10) begin
			sum_mod = 4'(sum_raw - 6'd10);
		end else begin
			sum_mod = 4'(sum_raw);
		end
	end

	always_comb begin
		position_d = position_q;
		parity_d   = parity_q;
		sum_d      = sum_q;
		skip_d     = skip_q;
		res_n      = 2'd0;

		res0              = '0;
		res0.module_count = COUNT_NONE;
		res0.code_done    = 1'b1;
		res0.status       = STATUS_OK;
		res0.run_last     = 1'b1;
		res1              = '0;
		res1.modules      = GUARD_SIDE;
		res1.module_count = COUNT_SIDE;
		res1.code_done    = 1'b1;
		res1.status       = STATUS_OK;
		res1.run_last     = 1'b1;

		if (skip_q) begin
			if (req.last_char) begin
				position_d = '0;
				parity_d   = '0;
				sum_d      = '0;
				skip_d     = 1'b0;
			end
		end else if (length_err || !is_digit ||
			(position_q >= LAST_POSITION && digit != check)) begin
			res_n      = 2'd1;
			position_d = '0;
			parity_d   = '0;
			sum_d      = '0;
			if (length_err) begin
				res0.status = STATUS_LENGTH;
			end else if (!is_digit) begin
				res0.status = STATUS_NON_DIGIT;
			end else begin
				res0.status = STATUS_CHECK;
			end
			skip_d = !req.last_char;
		end else if (position_q >= LAST_POSITION) begin
			res_n             = 2'd2;
			res0.modules      = r_code;
			res0.module_count = COUNT_DIGIT;
			res0.code_done    = 1'b0;
			res0.run_last     = 1'b0;
			position_d        = '0;
			parity_d          = '0;
			sum_d             = '0;
		end else begin
			res_n             = 2'd1;
			position_d        = position_q + 4'd1;
			sum_d             = sum_mod;
			res0.code_done    = 1'b0;
			res0.module_count = COUNT_DIGIT;
			if (position_q == 4'd0) begin
				parity_d          = parity_of(digit);
				res0.modules      = GUARD_SIDE;
				res0.module_count = COUNT_SIDE;
			end else if (position_q <= CENTRE_POSITION) begin
				res0.modules = left_code;
				if (position_q == CENTRE_POSITION) begin
					res_n             = 2'd2;
					res0.run_last     = 1'b0;
					res1.modules      = GUARD_CENTRE;
					res1.module_count = COUNT_CENTRE;
					res1.code_done    = 1'b0;
				end
			end else begin
				res0.modules = r_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			parity_q   <= '0;
			sum_q      <= '0;
			skip_q     <= 1'b0;
		end else if (req_take) begin
			position_q <= position_d;
			parity_q   <= parity_d;
			sum_q      <= sum_d;
			skip_q     <= skip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (rsp_take) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (req_take) begin
				wr_ptr_q <= wr_ptr_q + res_n;
			end
			count_q <= count_q + (req_take ? 3'(res_n) : 3'd0) - (rsp_take ? 3'd1 : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (req_take && res_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (req_take && res_n == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ean13_checker.sv
// Port checker for the EAN-13 encoder, bound to its top level.
`default_nettype none
`include "ean13_barcode_encoder_macros.svh"

module ean13_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  rsp_valid,
	input wire                  rsp_stall,
	input wire ean13_pkg::rsp_t rsp
);
	import ean13_pkg::*;

	logic rsp_waits;
	logic rsp_empty;
	logic rsp_open;
	logic count_legal;
	logic error_shape;
	logic status_ok;

	assign rsp_waits   = rsp_valid && rsp_stall;
	assign rsp_empty   = rsp_valid && rsp.module_count == COUNT_NONE;
	assign rsp_open    = rsp_valid && !rsp.code_done;
	assign count_legal = rsp.module_count == COUNT_NONE || rsp.module_count == COUNT_SIDE ||
		rsp.module_count == COUNT_CENTRE || rsp.module_count == COUNT_DIGIT;
	assign error_shape = rsp.code_done && rsp.run_last && rsp.status != STATUS_OK &&
		rsp.modules == 7'd0;
	assign status_ok   = rsp.status == STATUS_OK;

	`EAN13_ASSERT_NEXT(a_rsp_hold, rsp_waits, rsp_valid && $stable(rsp), "stalled result changed")
	`EAN13_ASSERT_NOW(a_count_legal, rsp_valid, count_legal, "illegal module count")
	`EAN13_ASSERT_NOW(a_error_shape, rsp_empty, error_shape, "malformed error result")
	`EAN13_ASSERT_NOW(a_status_open, rsp_open, status_ok, "status set before the code closes")

endmodule

bind ean13_barcode_encoder ean13_checker u_checker (.*);

`default_nettype wire
